### src/touch_press_debounce_and_position_top_defines.svh
// Assertion macros for the touch press block.
`ifndef TOUCH_PRESS_DEBOUNCE_AND_POSITION_TOP_DEFINES_SVH
`define TOUCH_PRESS_DEBOUNCE_AND_POSITION_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TPD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define TPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/tpd_pkg.sv
// Shared types and constants for the touch press block.
package tpd_pkg;

    localparam int SAMPLES_DEFAULT = 10;
    localparam int SAMPLES_MAX     = 16;

    localparam int RAW_W      = 12;
    localparam int PIX_W      = 13;
    localparam int OUT_W      = 16;
    localparam int MS_W       = 32;
    localparam int DEB_W      = 16;
    localparam int SUM_W      = RAW_W + $clog2(SAMPLES_MAX);
    localparam int CNT_W      = $clog2(SAMPLES_MAX + 1);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int DIV_N_W    = 24;
    localparam int DIV_D_W    = RAW_W;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [OUT_W-1:0] NO_POSITION = '1;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_MEAS = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RAW_X_START    = 3'd0,
        REG_RAW_X_END      = 3'd1,
        REG_RAW_Y_START    = 3'd2,
        REG_RAW_Y_END      = 3'd3,
        REG_PIXEL_WIDTH    = 3'd4,
        REG_PIXEL_HEIGHT   = 3'd5,
        REG_PRESSURE_LIMIT = 3'd6,
        REG_DEBOUNCE_MS    = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic             func;
        logic             pen_down;
        logic [RAW_W-1:0] z1_raw;
        logic [RAW_W-1:0] z2_raw;
        logic [RAW_W-1:0] x_raw;
        logic [RAW_W-1:0] y_raw;
    } req_t;

    typedef struct packed {
        logic             pressed;
        logic             position_ready;
        logic [OUT_W-1:0] x_pixel;
        logic [OUT_W-1:0] y_pixel;
    } rsp_t;

    typedef struct packed {
        logic [RAW_W-1:0] raw_x_start;
        logic [RAW_W-1:0] raw_x_end;
        logic [RAW_W-1:0] raw_y_start;
        logic [RAW_W-1:0] raw_y_end;
        logic [PIX_W-1:0] pixel_width;
        logic [PIX_W-1:0] pixel_height;
        logic [RAW_W-1:0] pressure_limit;
        logic [DEB_W-1:0] debounce_ms;
    } cfg_t;

    // Classified measurement handed from front to back.
    typedef struct packed {
        logic             pressed;
        logic             ready;
        logic [SUM_W-1:0] sum_x;
        logic [SUM_W-1:0] sum_y;
        logic [CNT_W-1:0] count;
    } job_t;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quotient;
    } div_rsp_t;

endpackage

### src/tpd_front.sv
// Front end: millisecond counter, press debounce and window accumulation.
module tpd_front #(
    parameter int SAMPLES_PER_POSITION = tpd_pkg::SAMPLES_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  tpd_pkg::cfg_t cfg,
    input  logic          req_valid,
    output logic          req_ready,
    input  tpd_pkg::req_t req,
    output logic          job_valid,
    input  logic          job_ready,
    output tpd_pkg::job_t job
);
    import tpd_pkg::*;

    logic [MS_W-1:0]  now_ms_reg, debounce_start_reg, debounce_start_next;
    logic             debounce_active_reg, debounce_active_next;
    logic             touched_reg, touched_next;
    logic [SUM_W-1:0] sum_x_reg, sum_y_reg, sum_x_next, sum_y_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic             accept;
    logic [RAW_W-1:0] pressure;
    logic             firm;
    logic [MS_W-1:0]  elapsed;
    logic             pressed;
    logic             ready;
    logic [SUM_W-1:0] sum_x_add, sum_y_add;
    logic [CNT_W-1:0] count_add;

    assign req_ready = job_ready;
    assign accept    = req_valid && req_ready;
    assign job_valid = accept && (req.func == FUNC_MEAS);

    assign pressure = (req.z2_raw > req.z1_raw) ? (req.z2_raw - req.z1_raw)
                                                : (req.z1_raw - req.z2_raw);
    assign firm     = pressure <= cfg.pressure_limit;
    // A fresh debounce starts at zero elapsed time.
    assign elapsed  = debounce_active_reg ? (now_ms_reg - debounce_start_reg) : '0;

    always_comb
    begin
        touched_next         = touched_reg;
        debounce_active_next = debounce_active_reg;
        debounce_start_next  = debounce_start_reg;
        if (req.pen_down)
        begin
            if (!touched_reg && firm)
            begin
                debounce_active_next = 1'b1;
                if (!debounce_active_reg)
                begin
                    debounce_start_next = now_ms_reg;
                end
                if (elapsed >= MS_W'(cfg.debounce_ms))
                begin
                    touched_next         = 1'b1;
                    debounce_active_next = 1'b0;
                end
            end
            else if (touched_reg && !firm)
            begin
                touched_next = 1'b0;
            end
            else
            begin
                debounce_active_next = 1'b0;
            end
        end
    end

    assign pressed   = req.pen_down && touched_next;
    assign sum_x_add = sum_x_reg + SUM_W'(req.x_raw);
    assign sum_y_add = sum_y_reg + SUM_W'(req.y_raw);
    assign count_add = count_reg + 1'b1;

    always_comb
    begin
        if (pressed)
        begin
            ready     = count_add >= CNT_W'(SAMPLES_PER_POSITION);
            job.sum_x = sum_x_add;
            job.sum_y = sum_y_add;
            job.count = count_add;
        end
        else
        begin
            // Not pressed closes a non-empty window early.
            ready     = count_reg != '0;
            job.sum_x = sum_x_reg;
            job.sum_y = sum_y_reg;
            job.count = count_reg;
        end
        job.pressed = pressed;
        job.ready   = ready;

        if (ready)
        begin
            sum_x_next = '0;
            sum_y_next = '0;
            count_next = '0;
        end
        else
        begin
            sum_x_next = job.sum_x;
            sum_y_next = job.sum_y;
            count_next = job.count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_ms_reg          <= '0;
            debounce_start_reg  <= '0;
            debounce_active_reg <= 1'b0;
            touched_reg         <= 1'b0;
            sum_x_reg           <= '0;
            sum_y_reg           <= '0;
            count_reg           <= '0;
        end
        else if (accept)
        begin
            if (req.func == FUNC_TICK)
            begin
                now_ms_reg <= now_ms_reg + 1'b1;
            end
            else
            begin
                debounce_start_reg  <= debounce_start_next;
                debounce_active_reg <= debounce_active_next;
                touched_reg         <= touched_next;
                sum_x_reg           <= sum_x_next;
                sum_y_reg           <= sum_y_next;
                count_reg           <= count_next;
            end
        end
    end

endmodule

### src/tpd_queue.sv
// Short queue of classified measurements between front and back.
module tpd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tpd_pkg::job_t push_job,
    output logic          not_full,
    input  logic          pop,
    output tpd_pkg::job_t pop_job,
    output logic          not_empty
);
    import tpd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    job_t              slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [FILL_W-1:0] fill_reg;

    assign not_full  = fill_reg != FILL_W'(QUEUE_DEPTH);
    assign not_empty = fill_reg != '0;
    assign pop_job   = slot_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

### src/tpd_div.sv
// Restoring divider, one quotient bit per cycle.
module tpd_div (
    input  logic              clk,
    input  logic              rst_n,
    input  tpd_pkg::div_req_t req,
    output tpd_pkg::div_rsp_t rsp
);
    import tpd_pkg::*;

    localparam int STEP_W = $clog2(DIV_N_W);

    logic               busy_reg;
    logic               done_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [DIV_D_W-1:0] divisor_reg;
    logic [DIV_D_W-1:0] rem_reg;
    logic [DIV_N_W-1:0] quo_reg;

    logic [DIV_D_W:0]   trial;
    logic               fits;
    logic [DIV_D_W-1:0] rem_next;

    assign trial    = {rem_reg, quo_reg[DIV_N_W-1]};
    assign fits     = trial >= {1'b0, divisor_reg};
    assign rem_next = fits ? DIV_D_W'(trial - {1'b0, divisor_reg}) : trial[DIV_D_W-1:0];

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            divisor_reg <= req.divisor;
            rem_reg     <= '0;
            quo_reg     <= req.dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DIV_N_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(DIV_N_W - 1);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

### src/tpd_back.sv
// Back end: window average, clamp and pixel mapping, result register.
module tpd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  tpd_pkg::cfg_t     cfg,
    input  logic              job_valid,
    input  tpd_pkg::job_t     job,
    output logic              job_pop,
    output tpd_pkg::div_req_t div_req,
    input  tpd_pkg::div_rsp_t div_rsp,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output tpd_pkg::rsp_t     rsp
);
    import tpd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_AVG_X,
        S_AVG_Y,
        S_MAP_X,
        S_DIV_X,
        S_MAP_Y,
        S_DIV_Y,
        S_FIN
    } state_t;

    state_t             state_reg;
    logic               pressed_reg;
    logic [SUM_W-1:0]   sum_y_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [RAW_W-1:0]   avg_x_reg, avg_y_reg;
    logic [OUT_W-1:0]   x_pix_reg;
    div_req_t           div_req_reg;
    logic               rsp_valid_reg;
    rsp_t               rsp_reg;

    logic               out_free;
    logic [RAW_W-1:0]   avg, lo, hi, clamped, span;
    logic [PIX_W-1:0]   pix;
    logic [RAW_W+PIX_W-1:0] product;

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign job_pop   = (state_reg == S_IDLE) && job_valid && out_free;
    assign div_req   = div_req_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // One clamp and multiplier shared by both axes.
    always_comb
    begin
        if (state_reg == S_MAP_Y)
        begin
            avg = avg_y_reg;
            lo  = cfg.raw_y_start;
            hi  = cfg.raw_y_end;
            pix = cfg.pixel_height;
        end
        else
        begin
            avg = avg_x_reg;
            lo  = cfg.raw_x_start;
            hi  = cfg.raw_x_end;
            pix = cfg.pixel_width;
        end
        if (avg < lo)
        begin
            clamped = lo;
        end
        else if (avg > hi)
        begin
            clamped = hi;
        end
        else
        begin
            clamped = avg;
        end
        span    = hi - lo;
        product = (clamped - lo) * pix;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            div_req_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
            pressed_reg   <= 1'b0;
            sum_y_reg     <= '0;
            count_reg     <= '0;
            avg_x_reg     <= '0;
            avg_y_reg     <= '0;
            x_pix_reg     <= '0;
        end
        else
        begin
            div_req_reg.start <= 1'b0;
            if (rsp_valid_reg && rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (job_pop)
                    begin
                        if (!job.ready)
                        begin
                            rsp_reg       <= '{job.pressed, 1'b0, NO_POSITION, NO_POSITION};
                            rsp_valid_reg <= 1'b1;
                        end
                        else
                        begin
                            pressed_reg <= job.pressed;
                            sum_y_reg   <= job.sum_y;
                            count_reg   <= job.count;
                            div_req_reg <= '{1'b1, DIV_N_W'(job.sum_x), DIV_D_W'(job.count)};
                            state_reg   <= S_AVG_X;
                        end
                    end
                end
                S_AVG_X:
                begin
                    if (div_rsp.done)
                    begin
                        avg_x_reg   <= div_rsp.quotient[RAW_W-1:0];
                        div_req_reg <= '{1'b1, DIV_N_W'(sum_y_reg), DIV_D_W'(count_reg)};
                        state_reg   <= S_AVG_Y;
                    end
                end
                S_AVG_Y:
                begin
                    if (div_rsp.done)
                    begin
                        avg_y_reg <= div_rsp.quotient[RAW_W-1:0];
                        state_reg <= S_MAP_X;
                    end
                end
                S_MAP_X:
                begin
                    if (hi <= lo)
                    begin
                        x_pix_reg <= NO_POSITION;
                        state_reg <= S_MAP_Y;
                    end
                    else
                    begin
                        div_req_reg <= '{1'b1, DIV_N_W'(product), span};
                        state_reg   <= S_DIV_X;
                    end
                end
                S_DIV_X:
                begin
                    if (div_rsp.done)
                    begin
                        x_pix_reg <= div_rsp.quotient[OUT_W-1:0];
                        state_reg <= S_MAP_Y;
                    end
                end
                S_MAP_Y:
                begin
                    if (hi <= lo)
                    begin
                        rsp_reg.y_pixel <= NO_POSITION;
                        state_reg       <= S_FIN;
                    end
                    else
                    begin
                        div_req_reg <= '{1'b1, DIV_N_W'(product), span};
                        state_reg   <= S_DIV_Y;
                    end
                end
                S_DIV_Y:
                begin
                    if (div_rsp.done)
                    begin
                        rsp_reg.y_pixel <= div_rsp.quotient[OUT_W-1:0];
                        state_reg       <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    // y_pixel already sits in the result register; no previous item waits there, since
                    // the job was popped only with the output free; the rest is written here.
                    if (out_free)
                    begin
                        rsp_reg.pressed        <= pressed_reg;
                        rsp_reg.position_ready <= 1'b1;
                        rsp_reg.x_pixel        <= x_pix_reg;
                        rsp_valid_reg          <= 1'b1;
                        state_reg              <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### src/touch_press_debounce_and_position_top.sv
// Top level of the touch press debounce and position block.
//
//  channel | signals                              | moves
//  --------+--------------------------------------+---------------------------------
//  req     | req_valid, req_ready, req            | tick or touch measurement item
//  rsp     | rsp_valid, rsp_ready, rsp            | one result item per measurement
//  cfg     | cfg_valid, cfg_ready, cfg_index/data | register write, always ready
//
//  A tick or a measurement item is taken by the front end while the queue is not full; a
//  tick gives no result. A measurement that closes no window goes through a queue slot,
//  is popped by the idle back end when the output is free and is offered on rsp from the
//  result register. A closing window takes up to four passes of the shared 24-step divider
//  (two averages, two pixel scales; a pixel scale is skipped when its calibration is bad).
//  The front keeps taking items while the back works, until the 2-entry queue fills.
//  Reset loads the register defaults and clears all control state; there is no clearing pass.
`include "touch_press_debounce_and_position_top_defines.svh"

module touch_press_debounce_and_position_top #(
    parameter int SAMPLES_PER_POSITION = tpd_pkg::SAMPLES_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_ready,
    input  tpd_pkg::req_t                      req,
    output logic                               rsp_valid,
    input  logic                               rsp_ready,
    output tpd_pkg::rsp_t                      rsp,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tpd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tpd_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import tpd_pkg::*;

    cfg_t     cfg_reg;
    job_t     front_job, queue_job;
    logic     front_push, queue_not_full, queue_not_empty, back_pop;
    div_req_t div_req;
    div_rsp_t div_rsp;

    // Register file, always ready; host must write only while the block is idle (not enforced).
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.raw_x_start    <= '0;
            cfg_reg.raw_x_end      <= RAW_W'(4095);
            cfg_reg.raw_y_start    <= '0;
            cfg_reg.raw_y_end      <= RAW_W'(4095);
            cfg_reg.pixel_width    <= PIX_W'(320);
            cfg_reg.pixel_height   <= PIX_W'(240);
            cfg_reg.pressure_limit <= RAW_W'(1000);
            cfg_reg.debounce_ms    <= DEB_W'(50);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                REG_RAW_X_START:    cfg_reg.raw_x_start    <= cfg_data[RAW_W-1:0];
                REG_RAW_X_END:      cfg_reg.raw_x_end      <= cfg_data[RAW_W-1:0];
                REG_RAW_Y_START:    cfg_reg.raw_y_start    <= cfg_data[RAW_W-1:0];
                REG_RAW_Y_END:      cfg_reg.raw_y_end      <= cfg_data[RAW_W-1:0];
                REG_PIXEL_WIDTH:    cfg_reg.pixel_width    <= cfg_data[PIX_W-1:0];
                REG_PIXEL_HEIGHT:   cfg_reg.pixel_height   <= cfg_data[PIX_W-1:0];
                REG_PRESSURE_LIMIT: cfg_reg.pressure_limit <= cfg_data[RAW_W-1:0];
                REG_DEBOUNCE_MS:    cfg_reg.debounce_ms    <= cfg_data[DEB_W-1:0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // Front: time base, debounce and window sums; pushes one job per measurement.
    tpd_front #(
        .SAMPLES_PER_POSITION(SAMPLES_PER_POSITION)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .job_valid(front_push),
        .job_ready(queue_not_full),
        .job      (front_job)
    );

    // Queue lets the front run on while the back divides.
    tpd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (front_push),
        .push_job (front_job),
        .not_full (queue_not_full),
        .pop      (back_pop),
        .pop_job  (queue_job),
        .not_empty(queue_not_empty)
    );

    // Back: averaging and mapping through one shared divider.
    tpd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .job_valid(queue_not_empty),
        .job      (queue_job),
        .job_pop  (back_pop),
        .div_req  (div_req),
        .div_rsp  (div_rsp),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

    tpd_div u_div (
        .clk(clk),
        .rst_n(rst_n),
        .req(div_req),
        .rsp(div_rsp)
    );

    // A result with no closed window carries no position.
    `TPD_ASSERT_NOW(a_no_pos_marker, rsp_valid && !rsp.position_ready, rsp.x_pixel == NO_POSITION && rsp.y_pixel == NO_POSITION, "result without window carries a position")
    // Bad x calibration forces the marker even when a window closed.
    `TPD_ASSERT_NOW(a_bad_cal_x, rsp_valid && rsp.position_ready && cfg_reg.raw_x_end <= cfg_reg.raw_x_start, rsp.x_pixel == NO_POSITION, "bad x calibration gave a position")
    // A good mapping never lands past the pixel count.
    `TPD_ASSERT_NOW(a_x_in_range, rsp_valid && rsp.position_ready && cfg_reg.raw_x_end > cfg_reg.raw_x_start, rsp.x_pixel <= OUT_W'(cfg_reg.pixel_width), "x pixel beyond width")
    // A popped job that closes no window is offered as a result in the next cycle.
    `TPD_ASSERT_NEXT(a_plain_job_out, back_pop && !queue_job.ready, rsp_valid && !rsp.position_ready, "plain job did not reach the result register")

endmodule
